// ===== sv/pes_pkg.sv =====
`default_nettype none
package pes_pkg;

  localparam int MAX_LEN = 64;
  localparam int DATA_W  = 64;
  localparam int HALF_W  = DATA_W / 2;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } pes_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] p;
  } pes_mul_rsp_t;

endpackage
`default_nettype wire

// ===== sv/pes_if.sv =====
`default_nettype none
interface pes_in_if;
  import pes_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     is_last;

  modport source(output valid, output value, output is_last, input ready);
  modport sink(input valid, input value, input is_last, output ready);
endinterface

interface pes_out_if;
  import pes_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] product;
  logic                     is_last_res;
  logic                     truncated;

  modport source(output valid, output product, output is_last_res, output truncated,
                 input ready);
  modport sink(input valid, input product, input is_last_res, input truncated,
               output ready);
endinterface
`default_nettype wire

// ===== sv/pes_ram.sv =====
`default_nettype none
module pes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/pes_mul.sv =====
`default_nettype none
module pes_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pes_pkg::pes_mul_req_t req,
  output pes_pkg::pes_mul_rsp_t rsp
);
  import pes_pkg::*;

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [DATA_W-1:0] a_r, b_r, acc_r;
  logic [1:0]        step_r;
  logic              busy_r, done_r;
  logic [HALF_W-1:0] mx, my;
  logic [DATA_W-1:0] mres;

  always_comb begin
    case (step_r)
      STEP_LL: begin mx = a_r[HALF_W-1:0];      my = b_r[HALF_W-1:0]; end
      STEP_LH: begin mx = a_r[HALF_W-1:0];      my = b_r[DATA_W-1:HALF_W]; end
      STEP_HL: begin mx = a_r[DATA_W-1:HALF_W]; my = b_r[HALF_W-1:0]; end
      default: begin mx = '0;                   my = '0; end
    endcase
    mres = {{HALF_W{1'b0}}, mx} * {{HALF_W{1'b0}}, my};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= STEP_LL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_LL;
      end else if (busy_r) begin
        if (step_r == STEP_HL) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end else if (busy_r) begin
      if (step_r == STEP_LL) begin
        acc_r <= mres;
      end else begin
        acc_r[DATA_W-1:HALF_W] <= acc_r[DATA_W-1:HALF_W] + mres[HALF_W-1:0];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule
`default_nettype wire

// ===== sv/product_except_self_core.sv =====
`default_nettype none
// Takes a set of signed 64-bit elements, one per transfer (is_last ends the set), and then
// returns for each position the product of all other elements, modulo 2^64, in index order.
// Up to MAX_LEN elements are kept; later ones are dropped and every result of that set has
// truncated set. Loading accepts one element per cycle. After the last element the block makes
// a forward pass, a backward pass and an emit pass, which also waits out any output stall;
// the passes are paced by the shared 32x32 multiplier, which builds each 64-bit product
// from three partial products, and by the registered reads of the element and partial
// memories. No new element is taken until the last result of the set has been transferred.
module product_except_self_core (
  input  wire logic clk,
  input  wire logic rst_n,
  pes_in_if.sink    in_ch,
  pes_out_if.source out_ch
);
  import pes_pkg::*;

  typedef enum logic [7:0] {
    ST_LOAD    = 8'b0000_0001,
    ST_FWD_RD  = 8'b0000_0010,
    ST_FWD_MUL = 8'b0000_0100,
    ST_BWD_RD  = 8'b0000_1000,
    ST_BWD_MP  = 8'b0001_0000,
    ST_BWD_MR  = 8'b0010_0000,
    ST_EMIT_RD = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] run_r, run_nxt;
  logic              ovf_r, ovf_nxt;
  logic              wait_r, wait_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_product_r;
  logic              out_last_r;
  logic              out_load;

  logic              elem_we, elem_re, part_we, part_re;
  logic [IDX_W-1:0]  elem_waddr, part_waddr;
  logic [DATA_W-1:0] part_wdata, elem_rdata, part_rdata;

  pes_mul_req_t mul_req;
  pes_mul_rsp_t mul_rsp;

  logic in_xfer, out_xfer, idx_is_last;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign idx_is_last = ({{(CNT_W - IDX_W){1'b0}}, idx_r} + CNT_W'(1)) == count_r;

  pes_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (in_ch.value),
    .re    (elem_re),
    .raddr (idx_r),
    .rdata (elem_rdata)
  );

  pes_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_part_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata (part_wdata),
    .re    (part_re),
    .raddr (idx_r),
    .rdata (part_rdata)
  );

  pes_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    run_nxt       = run_r;
    ovf_nxt       = ovf_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    elem_we       = 1'b0;
    elem_re       = 1'b0;
    part_we       = 1'b0;
    part_re       = 1'b0;
    elem_waddr    = count_r[IDX_W-1:0];
    part_waddr    = idx_r;
    part_wdata    = run_r;
    mul_req.start = 1'b0;
    mul_req.a     = run_r;
    mul_req.b     = elem_rdata;

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (count_r < CNT_W'(MAX_LEN)) begin
            elem_we   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.is_last) begin
            idx_nxt   = '0;
            run_nxt   = DATA_W'(1);
            state_nxt = ST_FWD_RD;
          end
        end
      end
      ST_FWD_RD: begin
        elem_re   = 1'b1;
        part_we   = 1'b1;
        state_nxt = ST_FWD_MUL;
      end
      ST_FWD_MUL: begin
        mul_req.start = !wait_r;
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (mul_rsp.done) begin
          wait_nxt = 1'b0;
          if (idx_is_last) begin
            run_nxt   = DATA_W'(1);
            state_nxt = ST_BWD_RD;
          end else begin
            run_nxt   = mul_rsp.p;
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_FWD_RD;
          end
        end
      end
      ST_BWD_RD: begin
        elem_re   = 1'b1;
        part_re   = 1'b1;
        state_nxt = ST_BWD_MP;
      end
      ST_BWD_MP: begin
        mul_req.start = !wait_r;
        mul_req.a     = part_rdata;
        mul_req.b     = run_r;
        part_wdata    = mul_rsp.p;
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (mul_rsp.done) begin
          wait_nxt  = 1'b0;
          part_we   = 1'b1;
          state_nxt = ST_BWD_MR;
        end
      end
      ST_BWD_MR: begin
        mul_req.start = !wait_r;
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (mul_rsp.done) begin
          wait_nxt = 1'b0;
          run_nxt  = mul_rsp.p;
          if (idx_r == '0) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_BWD_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        part_re   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end else if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            run_nxt   = DATA_W'(1);
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      run_r       <= DATA_W'(1);
      ovf_r       <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      run_r       <= run_nxt;
      ovf_r       <= ovf_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_product_r <= part_rdata;
      out_last_r    <= idx_is_last;
    end
  end

  assign in_ch.ready        = (state_r == ST_LOAD);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.product     = out_product_r;
  assign out_ch.is_last_res = out_last_r;
  assign out_ch.truncated   = ovf_r;

endmodule
`default_nettype wire
